[hw/rtl/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types and constants of the fixed-point arithmetic unit
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int FRAC_W_DEF      = 8;
   localparam int QUEUE_DEPTH_DEF = 4;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_DIV  = 4'd3,
      OP_CMP  = 4'd4,
      OP_MIN  = 4'd5,
      OP_MAX  = 4'd6,
      OP_I2F  = 4'd7,
      OP_F2I  = 4'd8,
      OP_INC  = 4'd9,
      OP_DEC  = 4'd10
   } op_type;

   // one classified beat as it waits in the queue
   typedef struct packed {
      op_type             op;
      logic               known;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic               neg;
      logic        [31:0] ma;
      logic        [31:0] mb;
      logic               lt;
      logic               eq;
      logic               gt;
   } entry_type;

endpackage

[hw/rtl/fpa_front.sv]
// ----------------------------------------------------------------------------
// fpa_front
// decodes a request beat into an operation, magnitudes and compare flags
// ----------------------------------------------------------------------------
module fpa_front
   import fpa_pkg::*;
(
   input  logic        [3:0]  req_mode,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output entry_type          entry
);

   always_comb begin
      entry.op    = op_type'(req_mode);
      entry.known = (req_mode <= OP_DEC);
      entry.a     = req_operand_a;
      entry.b     = req_operand_b;
      entry.neg   = req_operand_a[31] ^ req_operand_b[31];
      entry.ma    = req_operand_a[31] ? 32'(-req_operand_a) : 32'(req_operand_a);
      entry.mb    = req_operand_b[31] ? 32'(-req_operand_b) : 32'(req_operand_b);
      entry.lt    = (req_operand_a < req_operand_b);
      entry.eq    = (req_operand_a == req_operand_b);
      entry.gt    = (req_operand_a > req_operand_b);
   end

endmodule

[hw/rtl/fpa_queue.sv]
// ----------------------------------------------------------------------------
// fpa_queue
// short fifo of classified beats between front and back
// ----------------------------------------------------------------------------
module fpa_queue
   import fpa_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output entry_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/fpa_back.sv]
// ----------------------------------------------------------------------------
// fpa_back
// executes queued beats: simple ops, two-step multiply, bit-serial divide
// ----------------------------------------------------------------------------
module fpa_back
   import fpa_pkg::*;
#(
   parameter int FRAC_W = FRAC_W_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  entry_type          head,
   output logic               pop,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_result,
   output logic               rsp_less,
   output logic               rsp_equal,
   output logic               rsp_greater,
   output logic               rsp_divide_by_zero,
   output logic               rsp_overflow
);

   localparam int NUM_W = 32 + FRAC_W;
   localparam int CNT_W = $clog2(NUM_W);

   typedef enum logic [3:0] {
      ST_RUN  = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DFIN = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [63:0]        prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        dvs_ff, dvs_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic               strobe_ff, strobe_in;
   logic signed [31:0] result_ff, result_in;
   logic               less_ff, less_in;
   logic               equal_ff, equal_in;
   logic               greater_ff, greater_in;
   logic               dz_ff, dz_in;
   logic               ovf_ff, ovf_in;

   logic [32:0]        shifted;
   logic               ge;
   logic [32:0]        diff;
   logic [64:0]        mag;
   logic [32:0]        sat;
   logic [32:0]        sum;
   logic [31+FRAC_W:0] shl;

   // saturate sign and magnitude, returns {overflow, value}
   function automatic logic [32:0] sat_mag(input logic neg, input logic [64:0] m);
      logic [32:0] r;
      if (neg) begin
         if (m > 65'h0_8000_0000) r = {1'b1, 32'h8000_0000};
         else                     r = {1'b0, 32'(-m[31:0])};
      end else begin
         if (m > 65'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
         else                     r = {1'b0, m[31:0]};
      end
      return r;
   endfunction

   // saturate a 33-bit signed sum, returns {overflow, value}
   function automatic logic [32:0] sat_sum(input logic [32:0] s);
      logic [32:0] r;
      if (s[32] != s[31]) r = {1'b1, s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
      else                r = {1'b0, s[31:0]};
      return r;
   endfunction

   assign pop = !empty && (state_ff == ST_RUN);

   // restoring divide step
   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign ge      = (shifted >= {1'b0, dvs_ff});
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      state_in   = state_ff;
      prod_in    = prod_ff;
      neg_in     = neg_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      cnt_in     = cnt_ff;
      strobe_in  = 1'b0;
      result_in  = result_ff;
      less_in    = less_ff;
      equal_in   = equal_ff;
      greater_in = greater_ff;
      dz_in      = dz_ff;
      ovf_in     = ovf_ff;
      mag        = '0;
      sat        = '0;
      sum        = '0;
      shl        = '0;

      unique case (state_ff)
         ST_RUN: begin
            if (pop) begin
               strobe_in  = 1'b1;
               result_in  = '0;
               less_in    = 1'b0;
               equal_in   = 1'b0;
               greater_in = 1'b0;
               dz_in      = 1'b0;
               ovf_in     = 1'b0;
               if (head.known) begin
                  unique case (head.op)
                     OP_ADD: begin
                        sum = {head.a[31], head.a} + {head.b[31], head.b};
                        sat = sat_sum(sum);
                        {ovf_in, result_in} = sat;
                     end
                     OP_SUB: begin
                        sum = {head.a[31], head.a} - {head.b[31], head.b};
                        sat = sat_sum(sum);
                        {ovf_in, result_in} = sat;
                     end
                     OP_INC: begin
                        sum = {head.a[31], head.a} + 33'd1;
                        sat = sat_sum(sum);
                        {ovf_in, result_in} = sat;
                     end
                     OP_DEC: begin
                        sum = {head.a[31], head.a} - 33'd1;
                        sat = sat_sum(sum);
                        {ovf_in, result_in} = sat;
                     end
                     OP_MUL: begin
                        strobe_in = 1'b0;
                        prod_in   = 64'(head.ma) * 64'(head.mb);
                        neg_in    = head.neg;
                        state_in  = ST_MUL;
                     end
                     OP_DIV: begin
                        if (head.mb == '0) begin
                           dz_in = 1'b1;
                        end else begin
                           strobe_in = 1'b0;
                           num_in    = {head.ma, {FRAC_W{1'b0}}};
                           rem_in    = '0;
                           dvs_in    = head.mb;
                           neg_in    = head.neg;
                           cnt_in    = CNT_W'(NUM_W - 1);
                           state_in  = ST_DIV;
                        end
                     end
                     OP_CMP: begin
                        less_in    = head.lt;
                        equal_in   = head.eq;
                        greater_in = head.gt;
                     end
                     OP_MIN: result_in = (head.lt || head.eq) ? head.a : head.b;
                     OP_MAX: result_in = (head.gt || head.eq) ? head.a : head.b;
                     OP_I2F: begin
                        shl = {head.a, {FRAC_W{1'b0}}};
                        if (shl[31+FRAC_W:31] != '0 && shl[31+FRAC_W:31] != '1) begin
                           ovf_in    = 1'b1;
                           result_in = head.a[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        end else begin
                           result_in = shl[31:0];
                        end
                     end
                     OP_F2I: begin
                        result_in = head.a[31] ? 32'(-(head.ma >> FRAC_W))
                                               : 32'(head.ma >> FRAC_W);
                     end
                     default: result_in = '0;
                  endcase
               end
            end
         end
         ST_MUL: begin
            mag = 65'(prod_ff[63:FRAC_W]) + 65'(prod_ff[FRAC_W-1]);
            sat = sat_mag(neg_ff, mag);
            {ovf_in, result_in} = sat;
            strobe_in = 1'b1;
            state_in  = ST_RUN;
         end
         ST_DIV: begin
            rem_in = ge ? diff[31:0] : shifted[31:0];
            num_in = {num_ff[NUM_W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DFIN;
            end
         end
         ST_DFIN: begin
            mag = 65'(num_ff) + 65'({rem_ff, 1'b0} >= {1'b0, dvs_ff});
            sat = sat_mag(neg_ff, mag);
            {ovf_in, result_in} = sat;
            strobe_in = 1'b1;
            state_in  = ST_RUN;
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_RUN;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      cnt_ff     <= cnt_in;
      result_ff  <= result_in;
      less_ff    <= less_in;
      equal_ff   <= equal_in;
      greater_ff <= greater_in;
      dz_ff      <= dz_in;
      ovf_ff     <= ovf_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_result         = result_ff;
   assign rsp_less           = less_ff;
   assign rsp_equal          = equal_ff;
   assign rsp_greater        = greater_ff;
   assign rsp_divide_by_zero = dz_ff;
   assign rsp_overflow       = ovf_ff;

`ifndef SYNTH
   a_cmp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $onehot0({rsp_less, rsp_equal, rsp_greater}))
      else $error("more than one compare flag");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_divide_by_zero |-> rsp_result == 0 && !rsp_overflow)
      else $error("divide by zero gave nonzero result or overflow");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_RUN |-> !pop)
      else $error("pop while multiply or divide in flight");

   a_div_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |=> !rsp_strobe)
      else $error("strobe during divide iterations");
`endif

endmodule

[hw/rtl/fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// fixed_point_alu
// signed 32-bit fixed-point arithmetic unit with rounding and saturation
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  request   req_mode, req_operand_a/b               start high, busy low
//  response  rsp_result, rsp_less/equal/greater,     rsp_strobe, one cycle,
//            rsp_divide_by_zero, rsp_overflow        cannot be held off
//
//  add, sub, compare, min, max, conversions, inc, dec: one beat per cycle
//    while not busy and no multiply/divide stalls; queued, then registered
//  multiply: back end busy (32x32 multiplier, then round/saturate in ST_MUL)
//  divide: back end busy in ST_DIV and ST_DFIN, one quotient bit per cycle
//  a QUEUE_DEPTH-deep queue (default 4) decouples requests; busy = queue full
//  reset is synchronous and empties the queue and the back end
//
module fixed_point_alu
   import fpa_pkg::*;
#(
   parameter int FRAC_W      = FRAC_W_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic        [3:0]  req_mode,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_result,
   output logic               rsp_less,
   output logic               rsp_equal,
   output logic               rsp_greater,
   output logic               rsp_divide_by_zero,
   output logic               rsp_overflow
);

   entry_type entry;      // classified request beat
   entry_type head;       // oldest queued beat
   logic      full;
   logic      empty;
   logic      pop;

   // front: decode and classify
   fpa_front u_front (
      .req_mode      (req_mode),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .entry         (entry)
   );

   assign busy = full;

   // queue between front and back
   fpa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (start && !full),
      .push_data (entry),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (head)
   );

   // back: execute and register the response
   fpa_back #(
      .FRAC_W (FRAC_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .empty              (empty),
      .head               (head),
      .pop                (pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_result         (rsp_result),
      .rsp_less           (rsp_less),
      .rsp_equal          (rsp_equal),
      .rsp_greater        (rsp_greater),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .rsp_overflow       (rsp_overflow)
   );

endmodule
